// ===== sv/greedy_word_wrap_breaker_assert.svh =====
// Assertion macros shared by the word-wrap breaker modules.
// Each expects signals named clock and reset in the using scope.
`ifndef GREEDY_WORD_WRAP_BREAKER_ASSERT_SVH
`define GREEDY_WORD_WRAP_BREAKER_ASSERT_SVH

// Same-cycle implication.
`define GWWB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GWWB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/gwwb_pkg.sv =====
package gwwb_pkg;

   localparam int TEXT_CAPACITY = 1024;
   localparam int BREAK_LIMIT   = 64;

   // index width holds TEXT_CAPACITY itself
   localparam int IDX_W  = $clog2(TEXT_CAPACITY + 1);
   localparam int BC_W   = $clog2(BREAK_LIMIT);
   localparam int WID_W  = 16;
   localparam int CHAR_W = 8;

   // breaks one item can cause: start, wrap, newline/final
   localparam int SLOTS  = 3;
   localparam int SLOT_W = $clog2(SLOTS + 1);

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   typedef struct packed {
      logic [IDX_W-1:0] break_index;
      logic             last_break;
      logic             breaks_dropped;
   } result_type;

   typedef struct packed {
      logic [SLOT_W-1:0]           count;
      result_type [SLOTS-1:0]      slot;
   } bundle_type;

endpackage

// ===== sv/gwwb_core.sv =====
// Line-breaking state and per-item break generation.
`include "greedy_word_wrap_breaker_assert.svh"

module gwwb_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic [gwwb_pkg::CHAR_W-1:0]    char_code,
   input  logic [gwwb_pkg::WID_W-1:0]     glyph_advance,
   input  logic                           end_of_text,
   input  logic [gwwb_pkg::WID_W-1:0]     wrap_width,
   output gwwb_pkg::bundle_type           bundle
);

   typedef struct packed {
      gwwb_pkg::bundle_type         bun;
      logic [gwwb_pkg::BC_W-1:0]    bc;
      logic                         ovf;
   } track_type;

   localparam logic [gwwb_pkg::BC_W-1:0] BC_MAX = gwwb_pkg::BC_W'(gwwb_pkg::BREAK_LIMIT - 1);
   localparam logic [gwwb_pkg::IDX_W-1:0] CAP = gwwb_pkg::IDX_W'(gwwb_pkg::TEXT_CAPACITY);

   logic [gwwb_pkg::WID_W-1:0] line_pos_ff, line_pos_in;
   logic [gwwb_pkg::WID_W-1:0] word_wid_ff, word_wid_in;
   logic [gwwb_pkg::IDX_W-1:0] word_start_ff, word_start_in;
   logic [gwwb_pkg::IDX_W-1:0] char_idx_ff, char_idx_in;
   logic [gwwb_pkg::BC_W-1:0]  break_cnt_ff, break_cnt_in;
   logic                       started_ff, started_in;
   logic                       ovf_ff, ovf_in;

   function automatic logic [gwwb_pkg::WID_W-1:0] sat16(input logic [gwwb_pkg::WID_W+1:0] v);
      logic [gwwb_pkg::WID_W-1:0] r;
      r = (v[gwwb_pkg::WID_W+1:gwwb_pkg::WID_W] != 2'b00) ? '1 : v[gwwb_pkg::WID_W-1:0];
      return r;
   endfunction

   // Emit one break, or drop it once the non-final budget is spent.
   function automatic track_type put_break(input track_type t, input logic en,
                                           input logic [gwwb_pkg::IDX_W-1:0] idx,
                                           input logic last);
      track_type r;
      r = t;
      if (en) begin
         if (!last && (t.bc >= BC_MAX)) begin
            r.ovf = 1'b1;
         end else begin
            if (!last) begin
               r.bc = t.bc + gwwb_pkg::BC_W'(1);
            end
            r.bun.slot[t.bun.count[1:0]] = '{break_index: idx, last_break: last,
                                             breaks_dropped: t.ovf};
            r.bun.count = t.bun.count + gwwb_pkg::SLOT_W'(1);
         end
      end
      return r;
   endfunction

   logic                          wrap_on, active, is_nl, is_sp;
   logic [gwwb_pkg::WID_W:0]      sum_lw;
   logic                          over, over_end;
   logic [gwwb_pkg::WID_W+1:0]    ww_adv, lp_ww_adv;
   logic                          en2, en3, last3;
   logic [gwwb_pkg::IDX_W-1:0]    idx3;
   track_type                     t0, t1, t2, t3;

   assign wrap_on  = (wrap_width != '0);
   assign active   = !end_of_text && (char_idx_ff < CAP);
   assign is_nl    = (char_code == gwwb_pkg::CH_NEWLINE);
   assign is_sp    = (char_code == gwwb_pkg::CH_SPACE);
   assign sum_lw   = {1'b0, line_pos_ff} + {1'b0, word_wid_ff};
   assign over     = (sum_lw >= {1'b0, wrap_width});
   assign over_end = (sum_lw >  {1'b0, wrap_width});
   assign ww_adv    = {2'b00, word_wid_ff} + {2'b00, glyph_advance};
   assign lp_ww_adv = {2'b00, line_pos_ff} + {2'b00, word_wid_ff} + {2'b00, glyph_advance};

   // which of the later two breaks this item raises
   always_comb begin
      en2   = 1'b0;
      en3   = 1'b0;
      last3 = 1'b0;
      idx3  = char_idx_ff;
      if (end_of_text) begin
         en2   = wrap_on && over_end;
         en3   = 1'b1;
         last3 = 1'b1;
      end else if (active && wrap_on && is_nl) begin
         en2 = over;
         en3 = 1'b1;
      end else if (active && wrap_on && is_sp) begin
         en2 = over;
      end
   end

   always_comb begin
      t0.bun   = '0;
      t0.bc    = break_cnt_ff;
      t0.ovf   = ovf_ff;
      t1 = put_break(t0, !started_ff, '0, 1'b0);
      t2 = put_break(t1, en2, word_start_ff, 1'b0);
      t3 = put_break(t2, en3, idx3, last3);
   end

   assign bundle = t3.bun;

   always_comb begin
      line_pos_in   = line_pos_ff;
      word_wid_in   = word_wid_ff;
      word_start_in = word_start_ff;
      char_idx_in   = char_idx_ff;
      break_cnt_in  = t3.bc;
      ovf_in        = t3.ovf;
      started_in    = 1'b1;
      if (end_of_text) begin
         line_pos_in   = '0;
         word_wid_in   = '0;
         word_start_in = '0;
         char_idx_in   = '0;
         break_cnt_in  = '0;
         ovf_in        = 1'b0;
         started_in    = 1'b0;
      end else if (active) begin
         char_idx_in = char_idx_ff + gwwb_pkg::IDX_W'(1);
         if (wrap_on) begin
            if (is_nl) begin
               line_pos_in   = '0;
               word_wid_in   = '0;
               word_start_in = char_idx_ff + gwwb_pkg::IDX_W'(1);
            end else if (is_sp) begin
               line_pos_in   = over ? sat16(ww_adv) : sat16(lp_ww_adv);
               word_wid_in   = '0;
               word_start_in = char_idx_ff + gwwb_pkg::IDX_W'(1);
            end else begin
               word_wid_in = sat16(ww_adv);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff   <= '0;
         word_wid_ff   <= '0;
         word_start_ff <= '0;
         char_idx_ff   <= '0;
         break_cnt_ff  <= '0;
         started_ff    <= 1'b0;
         ovf_ff        <= 1'b0;
      end else if (fire) begin
         line_pos_ff   <= line_pos_in;
         word_wid_ff   <= word_wid_in;
         word_start_ff <= word_start_in;
         char_idx_ff   <= char_idx_in;
         break_cnt_ff  <= break_cnt_in;
         started_ff    <= started_in;
         ovf_ff        <= ovf_in;
      end
   end

   `GWWB_ASSERT_NEXT(a_end_clears, fire && end_of_text, !started_ff && (char_idx_ff == '0), "end item did not clear text state")
   `GWWB_ASSERT_NOW(a_bc_bound, 1'b1, break_cnt_ff <= BC_MAX, "break count past limit")
   `GWWB_ASSERT_NOW(a_start_break, fire && !started_ff, bundle.count != '0, "text start gave no break")

endmodule

// ===== sv/gwwb_rsp_queue.sv =====
// Two-entry queue of per-item break bundles, drained one break per transfer.
`include "greedy_word_wrap_breaker_assert.svh"

module gwwb_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  gwwb_pkg::bundle_type  push_bundle,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gwwb_pkg::result_type  rsp_result
);

   gwwb_pkg::bundle_type        entry_ff [2];
   logic                        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                  cnt_ff, cnt_in;
   logic [gwwb_pkg::SLOT_W-1:0] sub_ff;
   logic                        pop, pop_last;
   gwwb_pkg::bundle_type        head;

   assign head       = entry_ff[rd_ptr_ff];
   assign full       = (cnt_ff == 2'd2);
   assign rsp_valid  = (cnt_ff != 2'd0);
   assign rsp_result = head.slot[sub_ff[1:0]];
   assign pop        = rsp_valid && rsp_ready;
   assign pop_last   = pop && (sub_ff == head.count - gwwb_pkg::SLOT_W'(1));

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop_last) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && pop_last) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
         sub_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_last) begin
            rd_ptr_ff <= !rd_ptr_ff;
            sub_ff    <= '0;
         end else if (pop) begin
            sub_ff <= sub_ff + gwwb_pkg::SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   `GWWB_ASSERT_NOW(a_no_overrun, push, !full, "push into full queue")
   `GWWB_ASSERT_NEXT(a_drain_count, pop_last && !push, cnt_ff == $past(cnt_ff) - 2'd1, "queue count wrong after drain")
   `GWWB_ASSERT_NOW(a_idle_sub, cnt_ff == 2'd0, sub_ff == '0, "slot pointer moved with empty queue")

endmodule

// ===== sv/greedy_word_wrap_breaker.sv =====
// Greedy word-wrap breaker: one character per transfer in, break indices out.
// An item moves from the input register into the core once the break queue has
// room; its breaks are registered into the queue and offered from there.
// Throughput: one item per cycle unless the queue is full; one break per cycle
// leaves, so several-break items (text start, wrap plus newline) take longer.
// Reset (synchronous, active high) clears text state, queues and wrap_width.
module greedy_word_wrap_breaker (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gwwb_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [gwwb_pkg::WID_W-1:0]     req_glyph_advance,
   input  logic                           req_end_of_text,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gwwb_pkg::IDX_W-1:0]     rsp_break_index,
   output logic                           rsp_last_break,
   output logic                           rsp_breaks_dropped,
   // configuration
   input  logic                           csr_wr_en,
   input  logic [gwwb_pkg::WID_W-1:0]     csr_wr_data
);

   // input register stage
   logic                        in_valid_ff, in_valid_in;
   logic [gwwb_pkg::CHAR_W-1:0] char_ff;
   logic [gwwb_pkg::WID_W-1:0]  adv_ff;
   logic                        eot_ff;
   logic [gwwb_pkg::WID_W-1:0]  wrap_width_ff;

   logic                        req_xfer, core_fire, q_full;
   gwwb_pkg::bundle_type        bundle;
   gwwb_pkg::result_type        rsp_result;

   // The staged item moves into the core whenever the break queue has room;
   // the queue holds two whole bundles, so a new transfer is taken while
   // earlier breaks still wait on the result side.
   assign core_fire = in_valid_ff && !q_full;
   assign req_ready = !in_valid_ff || !q_full;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (core_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         wrap_width_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            wrap_width_ff <= csr_wr_data;
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         char_ff <= req_char_code;
         adv_ff  <= req_glyph_advance;
         eot_ff  <= req_end_of_text;
      end
   end

   // Width tracking and break generation: adds and width compares per item.
   gwwb_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (core_fire),
      .char_code     (char_ff),
      .glyph_advance (adv_ff),
      .end_of_text   (eot_ff),
      .wrap_width    (wrap_width_ff),
      .bundle        (bundle)
   );

   // Items that raise no break never enter the queue.
   gwwb_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (core_fire && (bundle.count != '0)),
      .push_bundle (bundle),
      .full        (q_full),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (rsp_result)
   );

   assign rsp_break_index    = rsp_result.break_index;
   assign rsp_last_break     = rsp_result.last_break;
   assign rsp_breaks_dropped = rsp_result.breaks_dropped;

endmodule
